// ===== design/ptt_pkg.sv =====
// Package with types, constants and codes of the periodic timer table unit.
package ptt_pkg;

    localparam int NUM_CHANNELS_DEF = 4;
    localparam int MAX_TIMERS_DEF   = 16;
    localparam int MAX_RESULTS      = 16;
    localparam int PERIOD_W         = 31;
    localparam int THREAD_W         = 8;
    localparam int CHAN_W           = 2;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_CANCEL = 2'd1,
        OP_TICK   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_EXPIRY   = 2'd0,
        KIND_CANCEL   = 2'd1,
        KIND_NOTFOUND = 2'd2,
        KIND_REJECT   = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0]          op;
        logic [CHAN_W-1:0]   channel;
        logic [THREAD_W-1:0] thread_id;
        logic [PERIOD_W-1:0] period_ms;
    } t_in_item;

    typedef struct packed {
        logic [THREAD_W-1:0] wake_thread;
        logic [CHAN_W-1:0]   result_channel;
        logic [1:0]          kind;
        logic                channel_running;
        logic                last;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_CSCAN,
        ST_CSHIFT,
        ST_CDONE,
        ST_TSCAN,
        ST_TEMIT,
        ST_TDONE,
        ST_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic append;
        logic idx_clr;
        logic idx_inc;
        logic shift;
        logic drop_last;
        logic tick_step;
        logic chan_inc;
        logic emit;
        logic emit_last;
        logic emit_cancel;
        logic emit_notfound;
        logic emit_reject;
        logic flush_last;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_op  op;
        logic start_ok;
        logic tick_ok;
        logic idx_end;
        logic chan_end;
        logic match;
        logic expire;
        logic emit_room;
        logic pend_valid;
        logic out_busy;
    } t_stat;

endpackage

// ===== design/ptt_ctrl.sv =====
// Controller state machine of the periodic timer table unit.
module ptt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  ptt_pkg::t_stat  i_stat,
    output ptt_pkg::t_cmd   o_cmd
);

    ptt_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ptt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ptt_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = ptt_pkg::ST_START;
                end
            end
            ptt_pkg::ST_START: begin
                unique case (i_stat.op)
                    ptt_pkg::OP_START:  n_state = i_stat.start_ok ? ptt_pkg::ST_IDLE
                                                                  : ptt_pkg::ST_OUT;
                    ptt_pkg::OP_CANCEL: n_state = ptt_pkg::ST_CSCAN;
                    ptt_pkg::OP_TICK:   n_state = i_stat.tick_ok ? ptt_pkg::ST_TSCAN
                                                                 : ptt_pkg::ST_IDLE;
                    default:            n_state = ptt_pkg::ST_IDLE;
                endcase
            end
            ptt_pkg::ST_CSCAN: begin
                priority if (i_stat.match) begin
                    n_state = ptt_pkg::ST_CSHIFT;
                end else if (i_stat.idx_end && i_stat.chan_end) begin
                    n_state = ptt_pkg::ST_OUT;
                end
            end
            ptt_pkg::ST_CSHIFT: begin
                if (i_stat.idx_end) begin
                    n_state = ptt_pkg::ST_CDONE;
                end
            end
            ptt_pkg::ST_CDONE: begin
                n_state = ptt_pkg::ST_OUT;
            end
            ptt_pkg::ST_TSCAN: begin
                priority if (i_stat.expire && i_stat.emit_room) begin
                    n_state = ptt_pkg::ST_TEMIT;
                end else if (i_stat.idx_end) begin
                    n_state = ptt_pkg::ST_TDONE;
                end
            end
            ptt_pkg::ST_TEMIT: begin
                if (!i_stat.out_busy) begin
                    n_state = i_stat.idx_end ? ptt_pkg::ST_TDONE : ptt_pkg::ST_TSCAN;
                end
            end
            ptt_pkg::ST_TDONE: begin
                priority if (!i_stat.pend_valid) begin
                    n_state = ptt_pkg::ST_IDLE;
                end else if (!i_stat.out_busy) begin
                    n_state = ptt_pkg::ST_OUT;
                end
            end
            ptt_pkg::ST_OUT: begin
                if (!i_stat.out_busy) begin
                    n_state = ptt_pkg::ST_IDLE;
                end
            end
            default: n_state = ptt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ptt_pkg::ST_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.load   = i_valid;
            end
            ptt_pkg::ST_START: begin
                o_cmd.idx_clr = 1'b1;
                unique case (i_stat.op)
                    ptt_pkg::OP_START: begin
                        o_cmd.append      = i_stat.start_ok;
                        o_cmd.emit_reject = !i_stat.start_ok;
                    end
                    default: ;
                endcase
            end
            ptt_pkg::ST_CSCAN: begin
                if (!i_stat.match) begin
                    if (i_stat.idx_end) begin
                        o_cmd.idx_clr       = 1'b1;
                        o_cmd.chan_inc      = 1'b1;
                        o_cmd.emit_notfound = i_stat.chan_end;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                    end
                end
            end
            ptt_pkg::ST_CSHIFT: begin
                o_cmd.shift     = !i_stat.idx_end;
                o_cmd.idx_inc   = !i_stat.idx_end;
                o_cmd.drop_last = i_stat.idx_end;
                o_cmd.idx_clr   = i_stat.idx_end;
            end
            ptt_pkg::ST_CDONE: begin
                o_cmd.emit_cancel = 1'b1;
            end
            ptt_pkg::ST_TSCAN: begin
                if (!(i_stat.expire && i_stat.emit_room)) begin
                    o_cmd.tick_step = 1'b1;
                    o_cmd.idx_inc   = !i_stat.idx_end;
                end
            end
            ptt_pkg::ST_TEMIT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.tick_step = 1'b1;
                    o_cmd.idx_inc   = 1'b1;
                    o_cmd.emit      = 1'b1;
                end
            end
            ptt_pkg::ST_TDONE: begin
                o_cmd.flush_last = i_stat.pend_valid && !i_stat.out_busy;
            end
            default: ;
        endcase
    end

endmodule

// ===== design/ptt_dp.sv =====
// Datapath of the periodic timer table unit: entry table, scan index and result registers.
module ptt_dp #(
    parameter int NUM_CHANNELS = ptt_pkg::NUM_CHANNELS_DEF,
    parameter int MAX_TIMERS   = ptt_pkg::MAX_TIMERS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ptt_pkg::t_in_item   i_in_data,
    input  ptt_pkg::t_cmd       i_cmd,
    output ptt_pkg::t_stat      o_stat,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ptt_pkg::t_out_item  o_out_data
);

    localparam int IDX_W   = $clog2(MAX_TIMERS);
    localparam int CNT_W   = $clog2(MAX_TIMERS + 1);
    localparam int RC_W    = $clog2(ptt_pkg::MAX_RESULTS + 1);
    localparam int SCAN_CH = (NUM_CHANNELS < (1 << ptt_pkg::CHAN_W)) ? NUM_CHANNELS
                                                                     : (1 << ptt_pkg::CHAN_W);

    logic [ptt_pkg::CHAN_W-1:0]   r_chan   [MAX_TIMERS];
    logic [ptt_pkg::THREAD_W-1:0] r_thread [MAX_TIMERS];
    logic [ptt_pkg::PERIOD_W-1:0] r_count  [MAX_TIMERS];
    logic [ptt_pkg::PERIOD_W-1:0] r_reload [MAX_TIMERS];
    logic [CNT_W-1:0]             r_used;
    logic [NUM_CHANNELS-1:0]      r_active;
    logic [NUM_CHANNELS-1:0]      w_ccount_nz;

    ptt_pkg::t_in_item            r_item;
    logic [CNT_W-1:0]             r_idx;
    logic [ptt_pkg::CHAN_W:0]     r_cch;
    logic [RC_W-1:0]              r_rcnt;
    logic                         r_pend_v;
    logic [ptt_pkg::THREAD_W-1:0] r_pend_thr;
    logic                         r_out_v;
    ptt_pkg::t_out_item           r_out;

    logic [IDX_W-1:0]             w_i;
    logic                         w_ch_ok;
    logic                         w_cur_act;
    logic                         w_cch_act;
    logic [ptt_pkg::PERIOD_W-1:0] w_dec;
    logic                         w_expire;
    logic                         w_match;
    logic                         w_out_busy;
    logic                         w_out_set;
    logic [ptt_pkg::CHAN_W-1:0]   w_cch;

    assign w_i       = r_idx[IDX_W-1:0];
    assign w_ch_ok   = 32'(r_item.channel) < NUM_CHANNELS;
    assign w_dec     = r_count[w_i] - 1'b1;
    assign w_expire  = (r_idx < r_used) && (r_chan[w_i] == r_item.channel) && (w_dec == '0);
    assign w_cch     = r_cch[ptt_pkg::CHAN_W-1:0];
    assign w_match   = (r_idx < r_used) && (r_chan[w_i] == w_cch)
                       && (r_thread[w_i] == r_item.thread_id);
    assign w_out_busy = r_out_v && !i_out_ready;
    assign w_out_set  = (i_cmd.emit && r_pend_v) || i_cmd.flush_last || i_cmd.emit_reject
                        || i_cmd.emit_cancel || i_cmd.emit_notfound;

    always_comb begin
        w_cur_act = 1'b0;
        w_cch_act = 1'b0;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (32'(r_item.channel) == c) begin
                w_cur_act = r_active[c];
            end
            if (32'(r_cch) == c) begin
                w_cch_act = r_active[c];
            end
        end
    end

    always_comb begin
        o_stat            = '0;
        o_stat.op         = ptt_pkg::t_op'(r_item.op);
        o_stat.start_ok   = w_ch_ok && (r_item.period_ms != '0)
                            && (r_used < CNT_W'(MAX_TIMERS));
        o_stat.tick_ok    = w_cur_act;
        o_stat.idx_end    = (r_idx + 1'b1 >= r_used) || (r_used == '0);
        o_stat.chan_end   = (32'(r_cch) + 1 >= SCAN_CH);
        o_stat.match      = w_match;
        o_stat.expire     = w_expire;
        o_stat.emit_room  = r_rcnt < RC_W'(ptt_pkg::MAX_RESULTS);
        o_stat.pend_valid = r_pend_v;
        o_stat.out_busy   = w_out_busy;
    end

    // Channel activity follows the number of entries each channel holds.
    always_comb begin
        w_ccount_nz = '0;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            for (int k = 0; k < MAX_TIMERS; k++) begin
                if ((CNT_W'(k) < r_used) && (32'(r_chan[k]) == c)
                        && !(i_cmd.drop_last && CNT_W'(k) + 1'b1 == r_used)) begin
                    w_ccount_nz[c] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_data;
        end
        if (i_cmd.append) begin
            r_chan[r_used[IDX_W-1:0]]   <= r_item.channel;
            r_thread[r_used[IDX_W-1:0]] <= r_item.thread_id;
            r_count[r_used[IDX_W-1:0]]  <= r_item.period_ms;
            r_reload[r_used[IDX_W-1:0]] <= r_item.period_ms;
        end
        if (i_cmd.shift) begin
            r_chan[w_i]   <= r_chan[w_i + 1'b1];
            r_thread[w_i] <= r_thread[w_i + 1'b1];
            r_count[w_i]  <= r_count[w_i + 1'b1];
            r_reload[w_i] <= r_reload[w_i + 1'b1];
        end
        if (i_cmd.tick_step && r_idx < r_used && r_chan[w_i] == r_item.channel) begin
            r_count[w_i] <= (w_dec == '0) ? r_reload[w_i] : w_dec;
        end
        if (i_cmd.emit) begin
            r_pend_thr <= r_thread[w_i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_active <= '0;
            r_idx    <= '0;
            r_cch    <= '0;
            r_rcnt   <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_cch  <= '0;
                r_rcnt <= '0;
            end
            if (i_cmd.append) begin
                r_used <= r_used + 1'b1;
                for (int c = 0; c < NUM_CHANNELS; c++) begin
                    if (32'(r_item.channel) == c) begin
                        r_active[c] <= 1'b1;
                    end
                end
            end
            if (i_cmd.drop_last) begin
                r_used   <= r_used - 1'b1;
                r_active <= w_ccount_nz;
            end
            priority if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.chan_inc) begin
                r_cch <= r_cch + 1'b1;
            end
            priority if (w_out_set) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready && r_out_v) begin
                r_out_v <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_rcnt   <= r_rcnt + 1'b1;
                r_pend_v <= 1'b1;
            end
            if (i_cmd.flush_last) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_cmd.emit_reject) begin
            r_out.wake_thread     <= r_item.thread_id;
            r_out.result_channel  <= r_item.channel;
            r_out.kind            <= ptt_pkg::KIND_REJECT;
            r_out.channel_running <= w_cur_act;
            r_out.last            <= 1'b1;
        end else if (i_cmd.emit_cancel) begin
            r_out.wake_thread     <= r_item.thread_id;
            r_out.result_channel  <= w_cch;
            r_out.kind            <= ptt_pkg::KIND_CANCEL;
            r_out.channel_running <= w_cch_act;
            r_out.last            <= 1'b1;
        end else if (i_cmd.emit_notfound) begin
            r_out.wake_thread     <= r_item.thread_id;
            r_out.result_channel  <= '0;
            r_out.kind            <= ptt_pkg::KIND_NOTFOUND;
            r_out.channel_running <= 1'b0;
            r_out.last            <= 1'b1;
        end else if ((i_cmd.emit && r_pend_v) || i_cmd.flush_last) begin
            r_out.wake_thread     <= r_pend_thr;
            r_out.result_channel  <= r_item.channel;
            r_out.kind            <= ptt_pkg::KIND_EXPIRY;
            r_out.channel_running <= 1'b1;
            r_out.last            <= i_cmd.flush_last;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule

// ===== design/periodic_timer_table_unit.sv =====
// Top level of the periodic timer table unit.
// The block keeps a table of periodic timers shared among tick channels.
// Input transfers carry a start, a cancel, a tick or a none item; output transfers
// carry wakeup and status results, the final one of each item marked last.
// One item is worked on at a time. A cancel walks the table once per
// channel to find the entry and then shifts the younger entries down. A
// tick walks the table once, one entry a cycle except where it stops to
// emit a result. Each result sits in an output register; while the
// receiver stalls, the walk waits at the next result. Ready returns once
// the final result of the item has been taken by the receiver. Reset
// clears the table and stops all channels at once; no item is to be taken
// during reset, which binds the sender: the block itself does not enforce it.
module periodic_timer_table_unit #(
    parameter int NUM_CHANNELS = ptt_pkg::NUM_CHANNELS_DEF,
    parameter int MAX_TIMERS   = ptt_pkg::MAX_TIMERS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  ptt_pkg::t_in_item   i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output ptt_pkg::t_out_item  o_data
);

    ptt_pkg::t_cmd  w_cmd;
    ptt_pkg::t_stat w_stat;

    ptt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    ptt_dp #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .MAX_TIMERS   (MAX_TIMERS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .o_out_data  (o_data)
    );

endmodule

// ===== design/ptt_checker.sv =====
// Port checker of the periodic timer table unit and its bind.
module ptt_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input ptt_pkg::t_in_item  i_data,
    input logic               o_valid,
    input logic               i_ready,
    input ptt_pkg::t_out_item o_data
);

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_data))
        else $error("Waiting input transfer changed.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("Stalled result changed.");

    a_no_take_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.last |-> !o_ready)
        else $error("Input taken before the final result.");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Result shown after reset.");

    a_reject_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.kind != ptt_pkg::KIND_EXPIRY |-> o_data.last)
        else $error("Single result not marked last.");

endmodule

bind periodic_timer_table_unit ptt_checker u_ptt_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);

// ===== dv/periodic_timer_table_unit_tb.sv =====
// Testbench for the periodic timer table unit: random and directed transfers checked by a scoreboard.
module periodic_timer_table_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCH = ptt_pkg::NUM_CHANNELS_DEF;
    localparam int NTIM = ptt_pkg::MAX_TIMERS_DEF;
    localparam int NRES = ptt_pkg::MAX_RESULTS;
    localparam int CW = ptt_pkg::CHAN_W;
    localparam int TW = ptt_pkg::THREAD_W;
    localparam int PW = ptt_pkg::PERIOD_W;
    localparam longint CYCLE_LIMIT = 2000000;

    class wakeup_scoreboard;
        logic [CW-1:0]       tab_chan [NTIM];
        logic [TW-1:0]       tab_thr [NTIM];
        logic [PW-1:0]       tab_cnt [NTIM];
        logic [PW-1:0]       tab_rel [NTIM];
        int                  used;
        bit                  running [NCH];
        ptt_pkg::t_out_item  pending [$];
        int                  mismatches;

        function new();
            used = 0;
            mismatches = 0;
            foreach (running[c]) running[c] = 0;
        endfunction

        function void push(logic [TW-1:0] thr, logic [CW-1:0] ch, ptt_pkg::t_kind k,
                           logic run, logic lst);
            ptt_pkg::t_out_item r;
            r.wake_thread = thr;
            r.result_channel = ch;
            r.kind = k;
            r.channel_running = run;
            r.last = lst;
            pending.push_back(r);
        endfunction

        function bit chan_used(int ch);
            for (int i = 0; i < used; i++)
                if (tab_chan[i] == ch) return 1;
            return 0;
        endfunction

        function void note_item(ptt_pkg::t_in_item it);
            int hits;
            int q0;
            bit found;
            hits = 0;
            found = 0;
            q0 = pending.size();
            case (ptt_pkg::t_op'(it.op))
                ptt_pkg::OP_START: begin
                    if (it.period_ms == 0 || used >= NTIM) begin
                        push(it.thread_id, it.channel, ptt_pkg::KIND_REJECT,
                             running[it.channel], 1'b1);
                    end else begin
                        tab_chan[used] = it.channel;
                        tab_thr[used] = it.thread_id;
                        tab_cnt[used] = it.period_ms;
                        tab_rel[used] = it.period_ms;
                        used++;
                        running[it.channel] = 1;
                    end
                end
                ptt_pkg::OP_CANCEL: begin
                    for (int c = 0; c < NCH && !found; c++) begin
                        for (int i = 0; i < used && !found; i++) begin
                            if (tab_chan[i] == c && tab_thr[i] == it.thread_id) begin
                                found = 1;
                                for (int k = i; k + 1 < used; k++) begin
                                    tab_chan[k] = tab_chan[k+1];
                                    tab_thr[k] = tab_thr[k+1];
                                    tab_cnt[k] = tab_cnt[k+1];
                                    tab_rel[k] = tab_rel[k+1];
                                end
                                used--;
                                running[c] = chan_used(c);
                                push(it.thread_id, CW'(c), ptt_pkg::KIND_CANCEL,
                                     running[c], 1'b1);
                            end
                        end
                    end
                    if (!found) push(it.thread_id, '0, ptt_pkg::KIND_NOTFOUND, 1'b0, 1'b1);
                end
                ptt_pkg::OP_TICK: begin
                    if (running[it.channel]) begin
                        for (int i = 0; i < used; i++) begin
                            if (tab_chan[i] == it.channel) begin
                                tab_cnt[i] = tab_cnt[i] - 1'b1;
                                if (tab_cnt[i] == 0) begin
                                    tab_cnt[i] = tab_rel[i];
                                    if (hits < NRES) begin
                                        push(tab_thr[i], it.channel, ptt_pkg::KIND_EXPIRY,
                                             1'b1, 1'b0);
                                        hits++;
                                    end
                                end
                            end
                        end
                        if (hits > 0) pending[q0 + hits - 1].last = 1'b1;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(ptt_pkg::t_out_item got);
            ptt_pkg::t_out_item exp_r;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result %p", got);
                return;
            end
            exp_r = pending.pop_front();
            if (got !== exp_r) begin
                mismatches++;
                if (mismatches <= 10) $display("Result mismatch: expected %p, got %p", exp_r, got);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    ptt_pkg::t_in_item  in_data;
    logic               out_valid;
    logic               out_ready;
    ptt_pkg::t_out_item out_data;

    wakeup_scoreboard sb;
    int  send_idle_pct = 12;
    int  recv_idle_pct = 69;
    longint cycles;
    logic [TW-1:0] live_threads [$];

    periodic_timer_table_unit u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_ready (in_ready),
        .i_data  (in_data),
        .o_valid (out_valid),
        .i_ready (out_ready),
        .o_data  (out_data)
    );

    initial begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    end

    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_item(ptt_pkg::t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_item(it);
        @(negedge clk);
    endtask

    task automatic send_fields(ptt_pkg::t_op op, int ch, int thr, int per);
        ptt_pkg::t_in_item it;
        it.op = op;
        it.channel = CW'(ch);
        it.thread_id = TW'(thr);
        it.period_ms = PW'(per);
        send_item(it);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task automatic random_phase(int n);
        int r;
        int ch;
        logic [TW-1:0] thr;
        int per;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            ch = $urandom_range(NCH - 1);
            if (r < 30) begin
                thr = TW'($urandom);
                case ($urandom_range(9))
                    0: per = 0;
                    1: per = $urandom;
                    default: per = $urandom_range(6, 1);
                endcase
                send_fields(ptt_pkg::OP_START, ch, int'(thr), per);
                live_threads.push_back(thr);
            end else if (r < 45) begin
                if (live_threads.size() != 0 && $urandom_range(3) != 0)
                    thr = live_threads[$urandom_range(live_threads.size() - 1)];
                else
                    thr = TW'($urandom);
                send_fields(ptt_pkg::OP_CANCEL, ch, int'(thr), $urandom);
            end else if (r < 97) begin
                send_fields(ptt_pkg::OP_TICK, ch, $urandom, $urandom);
            end else begin
                send_fields(ptt_pkg::OP_NONE, ch, $urandom, $urandom);
            end
        end
    endtask

    initial begin
        sb = new();
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        repeat (10) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        send_fields(ptt_pkg::OP_TICK, 0, 0, 0);
        send_fields(ptt_pkg::OP_CANCEL, 0, 'hFF, 0);
        send_fields(ptt_pkg::OP_START, 3, 'hFF, 0);
        send_fields(ptt_pkg::OP_START, 0, 'h00, 'h7FFF_FFFF);
        send_fields(ptt_pkg::OP_START, 3, 'hAA, 1);
        for (int i = 0; i < 14; i++) send_fields(ptt_pkg::OP_START, 1, i, 1 + (i % 2));
        send_fields(ptt_pkg::OP_START, 2, 'h55, 1);
        send_fields(ptt_pkg::OP_TICK, 1, 0, 0);
        send_fields(ptt_pkg::OP_TICK, 1, 0, 0);
        send_fields(ptt_pkg::OP_TICK, 3, 0, 0);
        send_fields(ptt_pkg::OP_CANCEL, 0, 'hAA, 0);
        send_fields(ptt_pkg::OP_NONE, 2, 'h12, 5);
        send_fields(ptt_pkg::OP_CANCEL, 0, 'h00, 0);
        drain();
        for (int i = 0; i < 14; i++) send_fields(ptt_pkg::OP_CANCEL, 2, i, 0);

        random_phase(110);
        drain();
        send_idle_pct = 69;
        recv_idle_pct = 12;
        random_phase(110);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(90);
        drain();

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// ===== files.f =====
design/ptt_pkg.sv
design/ptt_ctrl.sv
design/ptt_dp.sv
design/periodic_timer_table_unit.sv
design/ptt_checker.sv
dv/periodic_timer_table_unit_tb.sv
